### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/m3i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Widths, cofactor index table, item types and saturation for the 3x3 inverse.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int LANES  = 9;
    localparam int FIX_W  = 32;
    localparam int COF_W  = 64;
    localparam int DET_W  = 98;
    localparam int DMAG_W = 97;
    localparam int QUO_W  = 33;
    localparam int SHIFT  = 32;
    localparam int RND_W  = DET_W - SHIFT;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [FIX_W-1:0] SAT_POS    = {1'b0, {(FIX_W-1){1'b1}}};
    localparam logic [FIX_W-1:0] SAT_NEG    = {1'b1, {(FIX_W-1){1'b0}}};
    localparam logic [DET_W-1:0] ROUND_HALF = DET_W'(1) << (SHIFT - 1);

    // Cofactor k = m[i0]*m[i1] - m[i2]*m[i3]
    localparam logic [3:0] COF_IDX [LANES][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd7, 4'd2, 4'd8, 4'd1},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd8, 4'd0, 4'd6, 4'd2},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd6, 4'd1, 4'd7, 4'd0},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef logic [LANES-1:0][FIX_W-1:0] matrix_t;

    typedef struct packed {
        logic [LANES-1:0][COF_W-1:0] cof;
        logic [DMAG_W-1:0]           dmag;
        logic                        dneg;
        logic                        singular;
    } front_item_t;

    typedef struct packed {
        logic [DET_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        logic [DET_W-1:0]      dvs;
        logic [FIX_W-1:0]      det_q;
        logic                  singular;
    } div_item_t;

    typedef struct packed {
        logic [LANES-1:0][FIX_W-1:0] inv;
        logic [FIX_W-1:0]            det;
        logic                        singular;
    } result_t;

    // Magnitude plus sign to a saturated Q16.16 word; big forces saturation
    function automatic logic [FIX_W-1:0] sat_fix(input logic [RND_W-1:0] mag,
                                                  input logic neg, input logic big);
        logic [RND_W-1:0] neg_mag;
        logic [FIX_W-1:0] res;
        neg_mag = -mag;
        if (neg)
            res = (big || mag > RND_W'(SAT_NEG)) ? SAT_NEG : neg_mag[FIX_W-1:0];
        else
            res = (big || mag > RND_W'(SAT_POS)) ? SAT_POS : mag[FIX_W-1:0];
        return res;
    endfunction

endpackage

### design/m3i_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module m3i_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  m3i_pkg::front_item_t din,
    output logic                 full,
    input  logic                 pop,
    output m3i_pkg::front_item_t dout,
    output logic                 empty
);

    m3i_pkg::front_item_t               ent_reg [m3i_pkg::QDEPTH];
    logic [m3i_pkg::QPTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [m3i_pkg::QCNT_W-1:0]         cnt_reg, cnt_next;
    logic                               do_push, do_pop;

    assign full    = (cnt_reg == m3i_pkg::QCNT_W'(m3i_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = ent_reg[rd_ptr_reg];
    assign cnt_next = cnt_reg + m3i_pkg::QCNT_W'(do_push) - m3i_pkg::QCNT_W'(do_pop);

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // Store item
    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_ptr_reg] <= din;
    end

endmodule

### design/m3i_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_front
// Accept matrices, form cofactors and the exact determinant, classify singular.
// ----------------------------------------------------------------------------
module m3i_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  m3i_pkg::matrix_t     mat,
    output logic                 item_valid,
    output m3i_pkg::front_item_t item,
    input  logic                 q_full
);

    localparam int NSTG = 6;

    logic [NSTG-1:0]                      vld_reg;
    logic                                 en, take;

    logic signed [m3i_pkg::COF_W-1:0]     prod_reg [m3i_pkg::LANES][2];
    logic signed [m3i_pkg::COF_W-1:0]     prod_next [m3i_pkg::LANES][2];
    logic signed [m3i_pkg::FIX_W-1:0]     arow1_reg [3], arow2_reg [3];
    logic signed [m3i_pkg::COF_W-1:0]     cof2_reg [m3i_pkg::LANES];
    logic signed [m3i_pkg::COF_W-1:0]     cof3_reg [m3i_pkg::LANES];
    logic signed [m3i_pkg::COF_W-1:0]     cof4_reg [m3i_pkg::LANES];
    logic signed [m3i_pkg::COF_W-1:0]     cof5_reg [m3i_pkg::LANES];
    logic signed [m3i_pkg::COF_W-1:0]     ph3_reg [3];
    logic signed [m3i_pkg::COF_W:0]       pl3_reg [3];
    logic signed [m3i_pkg::DET_W-1:0]     term4_reg [3];
    logic signed [m3i_pkg::DET_W-1:0]     det5_reg;
    logic signed [m3i_pkg::DET_W-1:0]     det_abs;
    m3i_pkg::front_item_t                 item_reg, item_next;

    // Stall only when the last stage holds an item the queue cannot take
    assign en         = !vld_reg[NSTG-1] || !q_full;
    assign full       = !en;
    assign take       = push && en;
    assign item_valid = vld_reg[NSTG-1];
    assign item       = item_reg;

    // Pair products of every cofactor
    always_comb
    begin
        for (int k = 0; k < m3i_pkg::LANES; k++)
        begin
            prod_next[k][0] = $signed(mat[m3i_pkg::COF_IDX[k][0]])
                            * $signed(mat[m3i_pkg::COF_IDX[k][1]]);
            prod_next[k][1] = $signed(mat[m3i_pkg::COF_IDX[k][2]])
                            * $signed(mat[m3i_pkg::COF_IDX[k][3]]);
        end
    end

    // Magnitude and class of the determinant
    assign det_abs = det5_reg[m3i_pkg::DET_W-1] ? -det5_reg : det5_reg;

    always_comb
    begin
        for (int k = 0; k < m3i_pkg::LANES; k++)
            item_next.cof[k] = cof5_reg[k];
        item_next.dmag     = det_abs[m3i_pkg::DMAG_W-1:0];
        item_next.dneg     = det5_reg[m3i_pkg::DET_W-1];
        item_next.singular = (det5_reg == '0);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], take};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            for (int j = 0; j < 3; j++)
            begin
                arow1_reg[j] <= $signed(mat[j]);
                arow2_reg[j] <= arow1_reg[j];
                ph3_reg[j]   <= arow2_reg[j] * $signed(cof2_reg[3*j][63:32]);
                pl3_reg[j]   <= arow2_reg[j] * $signed({1'b0, cof2_reg[3*j][31:0]});
                term4_reg[j] <= (m3i_pkg::DET_W'(ph3_reg[j]) <<< 32)
                              + m3i_pkg::DET_W'(pl3_reg[j]);
            end
            for (int k = 0; k < m3i_pkg::LANES; k++)
            begin
                cof2_reg[k] <= prod_reg[k][0] - prod_reg[k][1];
                cof3_reg[k] <= cof2_reg[k];
                cof4_reg[k] <= cof3_reg[k];
                cof5_reg[k] <= cof4_reg[k];
            end
            det5_reg <= term4_reg[0] + term4_reg[1] + term4_reg[2];
            item_reg <= item_next;
        end
    end

endmodule

### design/m3i_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_back
// Divide each cofactor by the determinant, one quotient bit per stage,
// round, saturate and hold results in the output queue.
// ----------------------------------------------------------------------------
module m3i_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  m3i_pkg::front_item_t in_item,
    input  logic                 in_empty,
    output logic                 in_pop,
    output m3i_pkg::result_t     res,
    output logic                 empty,
    input  logic                 pop
);

    localparam int NDIV = m3i_pkg::QUO_W;

    logic                                 en;
    logic                                 v0_reg;
    logic [NDIV:0]                        dv_reg;
    logic [m3i_pkg::COF_W-1:0]            mag0_reg [m3i_pkg::LANES];
    logic [m3i_pkg::LANES-1:0]            neg0_reg;
    logic [m3i_pkg::DMAG_W-1:0]           dmag0_reg;
    logic                                 dneg0_reg, sing0_reg;
    m3i_pkg::div_item_t                   stg_reg [NDIV+1];
    m3i_pkg::div_item_t                   stg_next [NDIV+1];
    m3i_pkg::result_t                     res_next;

    m3i_pkg::result_t                     oq_reg [m3i_pkg::QDEPTH];
    logic [m3i_pkg::QPTR_W-1:0]           oq_wr_reg, oq_rd_reg;
    logic [m3i_pkg::QCNT_W-1:0]           oq_cnt_reg, oq_cnt_next;
    logic                                 oq_full, oq_push, oq_pop;

    assign oq_full = (oq_cnt_reg == m3i_pkg::QCNT_W'(m3i_pkg::QDEPTH));
    assign empty   = (oq_cnt_reg == '0);
    assign en      = !dv_reg[NDIV] || !oq_full;
    assign in_pop  = en && !in_empty;
    assign oq_push = en && dv_reg[NDIV];
    assign oq_pop  = pop && !empty;
    assign res     = oq_reg[oq_rd_reg];
    assign oq_cnt_next = oq_cnt_reg + m3i_pkg::QCNT_W'(oq_push)
                       - m3i_pkg::QCNT_W'(oq_pop);

    // Seed the divider: N>>33 against 2*|det|, and round the determinant;
    // then one restoring step per stage, low numerator bits being the low
    // bits of |det|
    always_comb
    begin
        logic [m3i_pkg::DET_W-1:0] rsum;
        logic [m3i_pkg::DET_W:0]   sh;
        logic                      ge;
        rsum = m3i_pkg::DET_W'(dmag0_reg) + m3i_pkg::ROUND_HALF;
        stg_next[0].dvs      = {dmag0_reg, 1'b0};
        stg_next[0].det_q    = m3i_pkg::sat_fix(rsum[m3i_pkg::DET_W-1:m3i_pkg::SHIFT],
                                                dneg0_reg, 1'b0);
        stg_next[0].singular = sing0_reg;
        for (int k = 0; k < m3i_pkg::LANES; k++)
        begin
            stg_next[0].lane[k].rem = m3i_pkg::DET_W'(mag0_reg[k])
                                    + m3i_pkg::DET_W'(dmag0_reg >> 33);
            stg_next[0].lane[k].ovf = (stg_next[0].lane[k].rem >= {dmag0_reg, 1'b0});
            stg_next[0].lane[k].quo = '0;
            stg_next[0].lane[k].neg = neg0_reg[k];
        end
        for (int s = 1; s <= NDIV; s++)
        begin
            stg_next[s] = stg_reg[s-1];
            for (int k = 0; k < m3i_pkg::LANES; k++)
            begin
                sh = {stg_reg[s-1].lane[k].rem, stg_reg[s-1].dvs[NDIV-s+1]};
                ge = (sh >= {1'b0, stg_reg[s-1].dvs});
                stg_next[s].lane[k].rem = ge ? m3i_pkg::DET_W'(sh - {1'b0, stg_reg[s-1].dvs})
                                             : sh[m3i_pkg::DET_W-1:0];
                stg_next[s].lane[k].quo = {stg_reg[s-1].lane[k].quo[NDIV-2:0], ge};
            end
        end
    end

    // Saturate quotients; singular matrices give zero entries
    always_comb
    begin
        for (int k = 0; k < m3i_pkg::LANES; k++)
            res_next.inv[k] = stg_reg[NDIV].singular ? '0
                : m3i_pkg::sat_fix(m3i_pkg::RND_W'(stg_reg[NDIV].lane[k].quo),
                                   stg_reg[NDIV].lane[k].neg, stg_reg[NDIV].lane[k].ovf);
        res_next.det      = stg_reg[NDIV].det_q;
        res_next.singular = stg_reg[NDIV].singular;
    end

    // Advance valid bits and output queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg     <= 1'b0;
            dv_reg     <= '0;
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (en)
            begin
                v0_reg <= !in_empty;
                dv_reg <= {dv_reg[NDIV-1:0], v0_reg};
            end
            if (oq_push)
                oq_wr_reg <= oq_wr_reg + 1'b1;
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + 1'b1;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < m3i_pkg::LANES; k++)
            begin
                mag0_reg[k] <= in_item.cof[k][m3i_pkg::COF_W-1] ? -in_item.cof[k]
                                                                : in_item.cof[k];
                neg0_reg[k] <= (in_item.cof[k] != '0)
                            && (in_item.cof[k][m3i_pkg::COF_W-1] != in_item.dneg);
            end
            dmag0_reg <= in_item.dmag;
            dneg0_reg <= in_item.dneg;
            sing0_reg <= in_item.singular;
            stg_reg   <= stg_next;
        end
        if (oq_push)
            oq_reg[oq_wr_reg] <= res_next;
    end

endmodule

### design/matrix3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 Q16.16 matrix inverse by adjugate over exact determinant.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive a00..a22 and push; the matrix is
//   taken on a clock edge where push is high and full is low.
//   Result side is a queue read port: while empty is low, inv00..inv22,
//   determinant and singular show the oldest result; pop takes it.
//   From acceptance to empty falling, a matrix passes through six front
//   stages (products, cofactors, split determinant products, sums,
//   classification), the middle queue register, 35 back stages (magnitudes,
//   divider seed, one quotient bit per stage for 33 bits) and the output
//   queue. One matrix is accepted every cycle while full is low; the rate is
//   set by the 33-stage divider running nine lanes in parallel.
//   When pop stays low the output queue fills, the back pipeline freezes,
//   then the middle queue fills and full rises; nothing is dropped.
//   Reset empties all queues and pipeline stages; no other state is kept.
// ----------------------------------------------------------------------------
module matrix3_inverse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] a00,
    input  logic signed [31:0] a01,
    input  logic signed [31:0] a02,
    input  logic signed [31:0] a10,
    input  logic signed [31:0] a11,
    input  logic signed [31:0] a12,
    input  logic signed [31:0] a20,
    input  logic signed [31:0] a21,
    input  logic signed [31:0] a22,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] inv00,
    output logic signed [31:0] inv01,
    output logic signed [31:0] inv02,
    output logic signed [31:0] inv10,
    output logic signed [31:0] inv11,
    output logic signed [31:0] inv12,
    output logic signed [31:0] inv20,
    output logic signed [31:0] inv21,
    output logic signed [31:0] inv22,
    output logic signed [31:0] determinant,
    output logic               singular
);

    m3i_pkg::matrix_t     mat;
    m3i_pkg::front_item_t f_item, q_item;
    m3i_pkg::result_t     res;
    logic                 f_valid, q_full, q_empty, q_pop;

    // Gather the matrix, row-major
    assign mat[0] = a00;
    assign mat[1] = a01;
    assign mat[2] = a02;
    assign mat[3] = a10;
    assign mat[4] = a11;
    assign mat[5] = a12;
    assign mat[6] = a20;
    assign mat[7] = a21;
    assign mat[8] = a22;

    m3i_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mat        (mat),
        .item_valid (f_valid),
        .item       (f_item),
        .q_full     (q_full)
    );

    m3i_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .din   (f_item),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_item),
        .empty (q_empty)
    );

    m3i_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (q_item),
        .in_empty (q_empty),
        .in_pop   (q_pop),
        .res      (res),
        .empty    (empty),
        .pop      (pop)
    );

    // Spread the result over the ports
    assign inv00       = res.inv[0];
    assign inv01       = res.inv[1];
    assign inv02       = res.inv[2];
    assign inv10       = res.inv[3];
    assign inv11       = res.inv[4];
    assign inv12       = res.inv[5];
    assign inv20       = res.inv[6];
    assign inv21       = res.inv[7];
    assign inv22       = res.inv[8];
    assign determinant = res.det;
    assign singular    = res.singular;

endmodule

### design/m3i_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks on the inverse block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module m3i_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               pop,
    input logic               empty,
    input logic signed [31:0] inv00,
    input logic signed [31:0] inv01,
    input logic signed [31:0] inv02,
    input logic signed [31:0] inv10,
    input logic signed [31:0] inv11,
    input logic signed [31:0] inv12,
    input logic signed [31:0] inv20,
    input logic signed [31:0] inv21,
    input logic signed [31:0] inv22,
    input logic signed [31:0] determinant,
    input logic               singular
);

    logic [7:0] cnt_reg, cnt_next;

    // Track items accepted but not yet taken
    assign cnt_next = cnt_reg + 8'(push && !full) - 8'(pop && !empty);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    `ASSERT_IMPL(a_no_orphan, !empty, cnt_reg != 8'd0, "result shown with no item outstanding")

    `ASSERT_IMPL(a_singular_zero, !empty && singular, inv00 == 0 && inv01 == 0 && inv02 == 0 && inv10 == 0 && inv11 == 0 && inv12 == 0 && inv20 == 0 && inv21 == 0 && inv22 == 0 && determinant == 0, "singular result with nonzero fields")

    `ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(inv00) && $stable(inv22) && $stable(determinant) && $stable(singular), "stalled result changed")

endmodule

bind matrix3_inverse m3i_checker u_m3i_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 Q16.16 matrix inverse. Matrices are pushed
// through the queue-style input, the inverse, determinant and singular flag
// are predicted exactly in 128-bit integer arithmetic, and every popped
// result is compared with the oldest prediction. Random idling on both sides,
// a long receiver hold-off that fills the block, and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LATENCY     = 60;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic empty;
    logic pop;
    logic signed [31:0] a [9];
    logic signed [31:0] inv [9];
    logic signed [31:0] determinant;
    logic singular;

    m3i_pkg::result_t inverse_q [$];
    int      errors;
    int      checked;
    int      singular_seen;
    int      cycles;
    bit      idle_on;
    bit      long_hold_req;
    bit      long_hold_on;
    int      hold_cnt;

    matrix3_inverse dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .a00(a[0]), .a01(a[1]), .a02(a[2]),
        .a10(a[3]), .a11(a[4]), .a12(a[5]),
        .a20(a[6]), .a21(a[7]), .a22(a[8]),
        .empty(empty), .pop(pop),
        .inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]),
        .inv10(inv[3]), .inv11(inv[4]), .inv12(inv[5]),
        .inv20(inv[6]), .inv21(inv[7]), .inv22(inv[8]),
        .determinant(determinant), .singular(singular)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Saturate a magnitude with sign to a Q16.16 word
    function automatic logic [31:0] saturate_q16(logic [127:0] mag, logic neg);
        if (neg)
            return (mag > 128'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
        return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    // Exact inverse by adjugate over determinant
    function automatic m3i_pkg::result_t predict_inverse(m3i_pkg::matrix_t m);
        logic signed [127:0] e [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        logic [127:0] dmag;
        logic [127:0] cmag;
        logic [127:0] quo;
        logic dneg;
        m3i_pkg::result_t r;
        for (int k = 0; k < 9; k++)
            e[k] = {{96{m[k][31]}}, m[k]};
        cof[0] = e[4] * e[8] - e[5] * e[7];
        cof[1] = e[7] * e[2] - e[8] * e[1];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[8] * e[0] - e[6] * e[2];
        cof[5] = e[2] * e[3] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[4] * e[6];
        cof[7] = e[6] * e[1] - e[7] * e[0];
        cof[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        r = '0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        dneg = det < 0;
        dmag = dneg ? -det : det;
        r.det = saturate_q16((dmag + 128'h8000_0000) >> 32, dneg);
        for (int k = 0; k < 9; k++)
        begin
            cmag = (cof[k] < 0) ? -cof[k] : cof[k];
            quo = ((cmag << 33) + dmag) / (dmag << 1);
            r.inv[k] = saturate_q16(quo, (cof[k] != 0) && ((cof[k] < 0) != dneg));
        end
        return r;
    endfunction

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, inverse_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Check each popped item against the oldest prediction
    always @(posedge clk)
    begin
        m3i_pkg::result_t want;
        if (rst_n && !empty && pop)
        begin
            if (inverse_q.size() == 0)
            begin
                $display("%0t: unexpected result, nothing outstanding", $time);
                errors++;
            end
            else
            begin
                want = inverse_q.pop_front();
                checked++;
                if (want.singular)
                    singular_seen++;
                for (int k = 0; k < 9; k++)
                    if (inv[k] !== want.inv[k])
                    begin
                        $display("%0t: inv[%0d] expected %h actual %h", $time, k,
                                 want.inv[k], inv[k]);
                        errors++;
                    end
                if (determinant !== want.det)
                begin
                    $display("%0t: determinant expected %h actual %h", $time,
                             want.det, determinant);
                    errors++;
                end
                if (singular !== want.singular)
                begin
                    $display("%0t: singular expected %b actual %b", $time,
                             want.singular, singular);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stall bursts and the long hold-off
    always @(negedge clk)
    begin
        logic nxt;
        nxt = 1'b1;
        if (long_hold_req && !long_hold_on)
        begin
            hold_cnt = 300;
            long_hold_on = 1'b1;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            nxt = 1'b0;
            if (hold_cnt == 0 && long_hold_on)
            begin
                long_hold_req = 1'b0;
                long_hold_on = 1'b0;
            end
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            hold_cnt = $urandom_range(0, 9);
            nxt = 1'b0;
        end
        pop <= nxt;
    end

    // Offer one matrix, with an occasional random gap first, and hold until taken
    task automatic send_matrix(m3i_pkg::matrix_t m);
        bit taken;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        push <= 1'b1;
        for (int k = 0; k < 9; k++)
            a[k] <= m[k];
        taken = 1'b0;
        while (!taken)
        begin
            taken = !full;
            @(negedge clk);
        end
        inverse_q.push_back(predict_inverse(m));
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        while (inverse_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] rand_entry(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: return $urandom_range(0, 64) - 32;
            default:
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0001_0000;
                    3: return 32'hFFFF_0000;
                    4: return 32'h0000_0000;
                    default: return 32'h0000_0001;
                endcase
        endcase
    endfunction

    function automatic m3i_pkg::matrix_t rand_matrix();
        m3i_pkg::matrix_t m;
        int mode;
        mode = $urandom_range(0, 3);
        for (int k = 0; k < 9; k++)
            m[k] = rand_entry(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : mode);
        // Make some of them singular: repeated row, zero column or scaled row
        case ($urandom_range(0, 9))
            0: for (int c = 0; c < 3; c++) m[6 + c] = m[c];
            1: for (int r = 0; r < 3; r++) m[r * 3 + 1] = '0;
            2: for (int c = 0; c < 3; c++) m[3 + c] = -m[c];
            default: ;
        endcase
        return m;
    endfunction

    function automatic m3i_pkg::matrix_t diag(logic [31:0] d0, logic [31:0] d1,
                                              logic [31:0] d2);
        m3i_pkg::matrix_t m;
        m = '0;
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
        return m;
    endfunction

    task automatic test_directed();
        m3i_pkg::matrix_t m;
        send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix('0);
        send_matrix(diag(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000));
        send_matrix({9{32'h8000_0000}});
        send_matrix({9{32'h7FFF_FFFF}});
        send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        // tiny nonzero determinant: rounds to zero, inverse saturates
        send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_matrix(diag(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001));
        // determinant right at the rounding tie
        send_matrix(diag(32'h0000_0001, 32'h0000_8000, 32'h0001_0000));
        send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0001_0000));
        send_matrix(diag(32'h0100_0000, 32'h0100_0000, 32'h0100_0000));
        // singular with nonzero entries
        m = '0;
        for (int k = 0; k < 9; k++)
            m[k] = 32'h0001_0000 * (k + 1);
        send_matrix(m);
        // permutation and negative-sign mix
        m = '0;
        m[1] = 32'hFFFF_0000;
        m[5] = 32'h0001_0000;
        m[6] = 32'h0003_0000;
        send_matrix(m);
        m = '0;
        m[0] = 32'h8000_0000;
        m[2] = 32'h7FFF_FFFF;
        m[4] = 32'h0000_0001;
        m[6] = 32'h7FFF_FFFF;
        m[8] = 32'h8000_0000;
        send_matrix(m);
        for (int k = 0; k < 4; k++)
        begin
            m = '0;
            for (int j = 0; j < 9; j++)
                m[j] = (j % 4 == 0) ? 32'h0001_0000 : rand_entry(3);
            send_matrix(m);
        end
        wait_drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_matrix(rand_matrix());
    endtask

    // Hold the receiver off while offering items back to back
    task automatic test_backpressure();
        idle_on = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 60; i++)
            send_matrix(rand_matrix());
        idle_on = 1'b1;
    endtask

    // Pause the sender until every prediction is matched, then carry on
    task automatic test_drain_pause();
        test_random(40);
        push <= 1'b0;
        wait_drain();
        @(negedge clk);
        test_random(40);
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        test_random(150);
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        errors = 0;
        checked = 0;
        singular_seen = 0;
        cycles = 0;
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        long_hold_on = 1'b0;
        hold_cnt = 0;
        for (int k = 0; k < 9; k++)
            a[k] = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(450);
        test_backpressure();
        test_drain_pause();
        test_random(380);
        test_no_idle();

        // Drain and let any stray result surface
        push <= 1'b0;
        wait_drain();
        repeat (LATENCY) @(negedge clk);
        if (inverse_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, inverse_q.size());
            errors++;
        end
        $display("Checked %0d inverses (%0d singular) across directed, random,",
                 checked, singular_seen);
        $display("back-pressure and drain phases; %0d mismatches.", errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### matrix3_inverse.f
+incdir+design
design/m3i_pkg.sv
design/m3i_queue.sv
design/m3i_front.sv
design/m3i_back.sv
design/matrix3_inverse.sv
design/m3i_checker.sv
verif/tb_top.sv
